// File: hdl/lru_register_allocator_assert.svh
// Assertion macros for the allocator RTL.
// Each macro expects clk and arst_n in scope.
`ifndef LRU_REGISTER_ALLOCATOR_ASSERT_SVH
`define LRU_REGISTER_ALLOCATOR_ASSERT_SVH

`ifndef SYNTH
// Same-cycle implication.
`define LRA_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("allocator assertion failed");
// Next-cycle implication.
`define LRA_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("allocator assertion failed");
`else
`define LRA_ASSERT_IMP(lbl, ante, cons)
`define LRA_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

// File: hdl/lra_pkg.sv
package lra_pkg;

	localparam int NUM_REGS    = 16;
	localparam int REG_W       = 4;
	localparam int ADDR_W      = 32;
	localparam int SIZE_W      = 4;
	localparam int FLAG_W      = 3;
	localparam int STAMP_W     = 32;
	localparam int MASK_W      = 16;
	localparam int IN_TDATA_W  = 64;
	localparam int OUT_TDATA_W = 56;

	// Access flag bit positions
	localparam int FL_READ   = 0;
	localparam int FL_WRITE  = 1;
	localparam int FL_ADDROF = 2;

	typedef enum logic [1:0] {
		KIND_ACQUIRE,
		KIND_RELEASE,
		KIND_RELEASE_MASK,
		KIND_FREEZE
	} kind_t;

	typedef enum logic [1:0] {
		USE_FREE,
		USE_VAR,
		USE_FROZEN,
		USE_ANON
	} use_t;

	typedef enum logic [1:0] {
		ST_OK,
		ST_BAD_SIZE,
		ST_BAD_ADDROF
	} status_t;

	typedef struct packed {
		kind_t              kind;
		logic               has_addr;
		logic [ADDR_W-1:0]  var_addr;
		logic [SIZE_W-1:0]  size_bytes;
		logic [FLAG_W-1:0]  access_flags;
		logic [REG_W-1:0]   reg_index;
		logic [MASK_W-1:0]  reg_mask;
	} req_t;

	typedef struct packed {
		logic [REG_W-1:0]   reg_out;
		logic               hit;
		logic               load_needed;
		logic               address_needed;
		logic               evicted;
		logic               writeback_needed;
		logic [ADDR_W-1:0]  writeback_addr;
		logic [SIZE_W-1:0]  writeback_size;
		logic [REG_W-1:0]   writeback_reg;
		status_t            status;
		logic               last;
	} res_t;

	// Controller to datapath commands
	typedef struct packed {
		logic load_req;
		logic acq_hit;
		logic acq_err;
		logic acq_free;
		logic scan_start;
		logic scan_step;
		logic acq_evict;
		logic rel_one;
		logic rel_step;
		logic freeze;
	} cmd_t;

	// Datapath to controller status
	typedef struct packed {
		kind_t kind;
		logic  hit;
		logic  size_bad;
		logic  free_any;
		logic  scan_last;
		logic  mask_empty;
		logic  mask_last;
		logic  out_free;
	} sts_t;

	// Index of the lowest set bit, zero if none
	function automatic logic [REG_W-1:0] lowest_set(input logic [NUM_REGS-1:0] v);
		logic [REG_W-1:0] r;
		r = '0;
		for (int i = NUM_REGS - 1; i >= 0; i--) begin
			if (v[i]) r = REG_W'(i);
		end
		return r;
	endfunction

endpackage

// File: hdl/lra_ctrl.sv
module lra_ctrl import lra_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_SCAN,
		S_EVICT,
		S_MASK
	} state_t;

	state_t state_q;
	logic   ready_q;

	assign in_ready = ready_q;

	// Decode commands from state and datapath status
	always_comb begin
		cmd = '0;
		unique case (state_q)
			S_IDLE: begin
				cmd.load_req = in_valid && ready_q;
			end
			S_DECODE: begin
				unique case (sts.kind)
					KIND_ACQUIRE: begin
						if (sts.hit) begin
							cmd.acq_hit = sts.out_free;
						end else if (sts.size_bad) begin
							cmd.acq_err = sts.out_free;
						end else if (sts.free_any) begin
							cmd.acq_free = sts.out_free;
						end else begin
							cmd.scan_start = 1'b1;
						end
					end
					KIND_RELEASE:      cmd.rel_one = sts.out_free;
					KIND_RELEASE_MASK: cmd.rel_one = 1'b0;
					KIND_FREEZE:       cmd.freeze  = sts.out_free;
					default:           cmd.rel_one = 1'b0;
				endcase
			end
			S_SCAN: begin
				cmd.scan_step = 1'b1;
			end
			S_EVICT: begin
				cmd.acq_evict = sts.out_free;
			end
			S_MASK: begin
				cmd.rel_step = !sts.mask_empty && sts.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	// Hold state and the input ready flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ready_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					ready_q <= 1'b1;
					if (cmd.load_req) begin
						state_q <= S_DECODE;
						ready_q <= 1'b0;
					end
				end
				S_DECODE: begin
					if (sts.kind == KIND_RELEASE_MASK) begin
						state_q <= S_MASK;
					end else if (cmd.scan_start) begin
						state_q <= S_SCAN;
					end else if (sts.out_free) begin
						state_q <= S_IDLE;
						ready_q <= 1'b1;
					end
				end
				S_SCAN: begin
					if (sts.scan_last) state_q <= S_EVICT;
				end
				S_EVICT: begin
					if (cmd.acq_evict) begin
						state_q <= S_IDLE;
						ready_q <= 1'b1;
					end
				end
				S_MASK: begin
					if (sts.mask_empty || (cmd.rel_step && sts.mask_last)) begin
						state_q <= S_IDLE;
						ready_q <= 1'b1;
					end
				end
				default: begin
					state_q <= S_IDLE;
					ready_q <= 1'b0;
				end
			endcase
		end
	end

endmodule

// File: hdl/lra_dp.sv
module lra_dp import lra_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  req_t in_req,
	input  cmd_t cmd,
	output sts_t sts,
	input  logic out_ready,
	output logic out_valid,
	output res_t out_res
);

	// Entry storage
	use_t               use_q   [NUM_REGS];
	logic [ADDR_W-1:0]  addr_q  [NUM_REGS];
	logic [SIZE_W-1:0]  size_q  [NUM_REGS];
	logic [FLAG_W-1:0]  flags_q [NUM_REGS];
	logic [STAMP_W-1:0] stamp_q [NUM_REGS];
	logic [STAMP_W-1:0] clock_q;

	// Current request and scan state
	req_t               req_q;
	logic [NUM_REGS-1:0] mask_q;
	logic [REG_W-1:0]   scan_idx_q;
	logic [REG_W-1:0]   best_idx_q;
	logic [STAMP_W-1:0] best_age_q;
	logic               found_q;

	// Output register
	logic out_valid_q;
	res_t out_res_q;

	logic [NUM_REGS-1:0] hit_vec;
	logic [NUM_REGS-1:0] free_vec;
	logic [REG_W-1:0]    hit_idx;
	logic [REG_W-1:0]    free_idx;
	logic [REG_W-1:0]    new_idx;
	logic [REG_W-1:0]    rel_idx;
	logic [REG_W-1:0]    mask_bit;
	logic [NUM_REGS-1:0] mask_rest;
	logic [REG_W-1:0]    sel_idx;
	logic                sel_wb;
	logic                size_ok;
	logic                addrof_bad;
	logic                in_range;
	logic [STAMP_W-1:0]  now;
	logic [STAMP_W-1:0]  age;
	logic                cand;
	logic                take;
	logic                res_fire;
	use_t                new_use;
	res_t                res_next;

	// Tag compare and free search across all entries
	always_comb begin
		for (int i = 0; i < NUM_REGS; i++) begin
			hit_vec[i]  = req_q.has_addr && (use_q[i] == USE_VAR) &&
				(addr_q[i] == req_q.var_addr);
			free_vec[i] = (use_q[i] == USE_FREE);
		end
	end

	assign hit_idx  = lowest_set(hit_vec);
	assign free_idx = lowest_set(free_vec);
	assign new_idx  = cmd.acq_evict ? best_idx_q : free_idx;
	assign new_use  = req_q.has_addr ? USE_VAR : USE_ANON;

	assign size_ok = (req_q.size_bytes == SIZE_W'(1)) || (req_q.size_bytes == SIZE_W'(2)) ||
		(req_q.size_bytes == SIZE_W'(4)) || (req_q.size_bytes == SIZE_W'(8));
	assign addrof_bad = req_q.access_flags[FL_ADDROF] && (req_q.size_bytes != SIZE_W'(8));

	assign now = clock_q + STAMP_W'(1);

	// One LRU candidate per cycle
	assign cand = (use_q[scan_idx_q] == USE_VAR) || (use_q[scan_idx_q] == USE_ANON);
	assign age  = now - stamp_q[scan_idx_q];
	assign take = cand && (!found_q || (age > best_age_q));

	assign rel_idx   = req_q.reg_index;
	assign in_range  = int'(req_q.reg_index) < NUM_REGS;
	assign mask_bit  = lowest_set(mask_q);
	assign mask_rest = mask_q & ~(NUM_REGS'(1) << mask_bit);

	// Entry that is cleared or evicted this cycle
	always_comb begin
		if (cmd.acq_evict) begin
			sel_idx = best_idx_q;
		end else if (cmd.rel_step) begin
			sel_idx = mask_bit;
		end else begin
			sel_idx = rel_idx;
		end
	end
	assign sel_wb = (use_q[sel_idx] == USE_VAR) && flags_q[sel_idx][FL_WRITE];

	// Build the result of the current action
	always_comb begin
		res_next      = '0;
		res_next.last = 1'b1;
		if (cmd.acq_hit) begin
			res_next.reg_out = hit_idx;
			res_next.hit     = 1'b1;
		end else if (cmd.acq_err) begin
			res_next.status = size_ok ? ST_BAD_ADDROF : ST_BAD_SIZE;
		end else if (cmd.acq_free || cmd.acq_evict) begin
			res_next.reg_out        = new_idx;
			res_next.load_needed    = req_q.access_flags[FL_READ] &&
				!req_q.access_flags[FL_ADDROF];
			res_next.address_needed = req_q.access_flags[FL_ADDROF];
			res_next.evicted        = cmd.acq_evict;
			if (cmd.acq_evict && sel_wb) begin
				res_next.writeback_needed = 1'b1;
				res_next.writeback_addr   = addr_q[sel_idx];
				res_next.writeback_size   = size_q[sel_idx];
				res_next.writeback_reg    = sel_idx;
			end
		end else if (cmd.rel_one) begin
			res_next.reg_out = req_q.reg_index;
			if (in_range && sel_wb) begin
				res_next.writeback_needed = 1'b1;
				res_next.writeback_addr   = addr_q[sel_idx];
				res_next.writeback_size   = size_q[sel_idx];
				res_next.writeback_reg    = sel_idx;
			end
		end else if (cmd.rel_step) begin
			res_next.reg_out = mask_bit;
			res_next.last    = (mask_rest == '0);
			if (sel_wb) begin
				res_next.writeback_needed = 1'b1;
				res_next.writeback_addr   = addr_q[sel_idx];
				res_next.writeback_size   = size_q[sel_idx];
				res_next.writeback_reg    = sel_idx;
			end
		end else if (cmd.freeze) begin
			res_next.reg_out = req_q.reg_index;
		end
	end

	assign res_fire = cmd.acq_hit || cmd.acq_err || cmd.acq_free || cmd.acq_evict ||
		cmd.rel_one || cmd.rel_step || cmd.freeze;

	// Update entries and the access clock
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_REGS; i++) begin
				use_q[i]   <= USE_FREE;
				addr_q[i]  <= '0;
				size_q[i]  <= '0;
				flags_q[i] <= '0;
				stamp_q[i] <= '0;
			end
			clock_q <= '0;
		end else begin
			if (cmd.acq_hit) begin
				flags_q[hit_idx] <= flags_q[hit_idx] | req_q.access_flags;
				stamp_q[hit_idx] <= now;
				clock_q          <= now;
			end
			if ((cmd.rel_one && in_range) || cmd.rel_step) begin
				use_q[sel_idx]   <= USE_FREE;
				addr_q[sel_idx]  <= '0;
				size_q[sel_idx]  <= '0;
				flags_q[sel_idx] <= '0;
				stamp_q[sel_idx] <= '0;
			end
			if (cmd.acq_free || cmd.acq_evict) begin
				use_q[new_idx]   <= new_use;
				addr_q[new_idx]  <= req_q.has_addr ? req_q.var_addr : '0;
				size_q[new_idx]  <= req_q.size_bytes;
				flags_q[new_idx] <= req_q.access_flags;
				stamp_q[new_idx] <= now;
				clock_q          <= now;
			end
			if (cmd.freeze && in_range && (use_q[rel_idx] == USE_FREE)) begin
				use_q[rel_idx] <= USE_FROZEN;
			end
		end
	end

	// Capture the request mask, advance the LRU scan and the release mask
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_idx_q <= '0;
			best_idx_q <= '0;
			found_q    <= 1'b0;
			mask_q     <= '0;
		end else begin
			if (cmd.load_req) begin
				mask_q <= in_req.reg_mask[NUM_REGS-1:0];
			end else if (cmd.rel_step) begin
				mask_q <= mask_rest;
			end
			if (cmd.scan_start) begin
				scan_idx_q <= '0;
				best_idx_q <= '0;
				found_q    <= 1'b0;
			end else if (cmd.scan_step) begin
				scan_idx_q <= scan_idx_q + REG_W'(1);
				if (take) begin
					best_idx_q <= scan_idx_q;
					found_q    <= 1'b1;
				end
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (cmd.load_req) req_q <= in_req;
		if (cmd.scan_step && take) best_age_q <= age;
		if (res_fire) out_res_q <= res_next;
	end

	// Output valid: set on a new result, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_res   = out_res_q;

	assign sts.kind       = req_q.kind;
	assign sts.hit        = |hit_vec;
	assign sts.size_bad   = !size_ok || addrof_bad;
	assign sts.free_any   = |free_vec;
	assign sts.scan_last  = (scan_idx_q == REG_W'(NUM_REGS - 1));
	assign sts.mask_empty = (mask_q == '0);
	assign sts.mask_last  = (mask_rest == '0);
	assign sts.out_free   = !out_valid_q || out_ready;

endmodule

// File: hdl/lru_register_allocator.sv
// Sixteen-entry fully associative register cache with LRU replacement. One request is
// processed at a time: acquires that hit, fail the size check or find a free entry,
// single releases and freezes finish in the decode state (tag compare and free search
// run combinationally across all entries). An acquire that must evict walks all 16
// entries one per cycle to find the oldest variable or anonymous entry, then evicts it.
// A masked release emits one result per set mask bit, one per cycle while the output
// register has room; an empty mask gives no result. A finished result waits in an
// output register so a new request can be accepted while it is held. Reset clears all
// entries at once; no clearing pass is needed.
`include "lru_register_allocator_assert.svh"

module lru_register_allocator import lra_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	// has_addr, var_addr[31:0], size_bytes[3:0], access_flags[2:0], reg_index[3:0],
	// reg_mask[15:0], zero pad
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
	// kind[1:0]
	input  logic [1:0]             s_axis_tuser,
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	// reg_out[3:0], hit, load_needed, address_needed, evicted, writeback_needed,
	// writeback_addr[31:0], writeback_size[3:0], writeback_reg[3:0], status[1:0], zero pad
	output logic [OUT_TDATA_W-1:0] m_axis_tdata,
	output logic                   m_axis_tlast
);

	req_t in_req;
	res_t out_res;
	cmd_t cmd;
	sts_t sts;
	logic [6:0] act_vec;
	logic res_cmd;

	// Unpack the request
	assign in_req.kind         = kind_t'(s_axis_tuser);
	assign in_req.has_addr     = s_axis_tdata[0];
	assign in_req.var_addr     = s_axis_tdata[32:1];
	assign in_req.size_bytes   = s_axis_tdata[36:33];
	assign in_req.access_flags = s_axis_tdata[39:37];
	assign in_req.reg_index    = s_axis_tdata[43:40];
	assign in_req.reg_mask     = s_axis_tdata[59:44];

	lra_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	lra_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_req    (in_req),
		.cmd       (cmd),
		.sts       (sts),
		.out_ready (m_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_res   (out_res)
	);

	// Pack the result
	assign m_axis_tdata = {5'b0, out_res.status, out_res.writeback_reg,
		out_res.writeback_size, out_res.writeback_addr, out_res.writeback_needed,
		out_res.evicted, out_res.address_needed, out_res.load_needed, out_res.hit,
		out_res.reg_out};
	assign m_axis_tlast = out_res.last;

	assign act_vec = {cmd.acq_hit, cmd.acq_err, cmd.acq_free, cmd.acq_evict,
		cmd.rel_one, cmd.rel_step, cmd.freeze};
	assign res_cmd = |act_vec;

	// At most one entry action per cycle
	`LRA_ASSERT_IMP(a_one_action, 1'b1, $onehot0(act_vec))
	// A result is only produced when the output register has room
	`LRA_ASSERT_IMP(a_result_room, res_cmd, sts.out_free)
	// The controller leaves idle right after taking a request
	`LRA_ASSERT_NXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready)

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
	import lra_pkg::*;

	localparam int ADDR_POOL   = 20;
	localparam int HOLD_CYCLES = 400;
	localparam int TAIL_CYCLES = 40;
	localparam int CYCLE_LIMIT = 400000;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
	logic [1:0]             s_axis_tuser = '0;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic                   m_axis_tlast;

	lru_register_allocator uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	// Shadow copy of the register cache
	use_t        slot_use   [NUM_REGS];
	logic [31:0] slot_addr  [NUM_REGS];
	logic [3:0]  slot_size  [NUM_REGS];
	logic [2:0]  slot_flags [NUM_REGS];
	logic [31:0] slot_stamp [NUM_REGS];
	logic [31:0] use_tick;

	req_t        req_backlog[$];
	res_t        outcome_q[$];
	req_t        cur_req;
	logic [31:0] addr_pool [ADDR_POOL];
	int          queued_cnt = 0;
	int          accepted_cnt = 0;
	int          mismatch_cnt = 0;
	int          send_idle_pct = 0;
	int          recv_idle_pct = 0;
	int          hold_token = 0;
	int          hold_seen = 0;
	int          hold_left = 0;
	int          cycle_cnt = 0;

	initial begin
		forever #6 clk = ~clk;
	end

	// Free an entry; report whether it held a dirty addressed variable
	function automatic bit vacate(input int r, output logic [31:0] wa, output logic [3:0] ws);
		bit dirty;
		dirty = slot_use[r] == USE_VAR && slot_flags[r][FL_WRITE];
		wa = slot_addr[r];
		ws = slot_size[r];
		slot_use[r]   = USE_FREE;
		slot_addr[r]  = '0;
		slot_size[r]  = '0;
		slot_flags[r] = '0;
		slot_stamp[r] = '0;
		return dirty;
	endfunction

	// Work out the results of one accepted request and queue them
	function automatic void predict_outcomes(req_t rq);
		res_t        o;
		logic [31:0] wa, now, age, best;
		logic [3:0]  ws;
		int          victim, n;
		bit          found;
		o = '0;
		o.last = 1'b1;
		case (rq.kind)
		KIND_ACQUIRE: begin
			victim = -1;
			if (rq.has_addr)
				for (int r = NUM_REGS - 1; r >= 0; r--)
					if (slot_use[r] == USE_VAR && slot_addr[r] == rq.var_addr) victim = r;
			if (victim >= 0) begin
				// hit: merge flags, refresh stamp, size untouched
				use_tick = use_tick + 1;
				slot_flags[victim] = slot_flags[victim] | rq.access_flags;
				slot_stamp[victim] = use_tick;
				o.reg_out = 4'(victim);
				o.hit = 1'b1;
			end else if (rq.size_bytes != 4'd1 && rq.size_bytes != 4'd2 &&
					rq.size_bytes != 4'd4 && rq.size_bytes != 4'd8) begin
				o.status = ST_BAD_SIZE;
			end else if (rq.access_flags[FL_ADDROF] && rq.size_bytes != 4'd8) begin
				o.status = ST_BAD_ADDROF;
			end else begin
				use_tick = use_tick + 1;
				now = use_tick;
				found = 1'b0;
				victim = 0;
				for (int r = NUM_REGS - 1; r >= 0; r--)
					if (slot_use[r] == USE_FREE) begin
						victim = r;
						found = 1'b1;
					end
				if (!found) begin
					// oldest variable or anonymous entry wins, lowest index on ties; entry 0 if all frozen
					best = '0;
					for (int r = 0; r < NUM_REGS; r++)
						if (slot_use[r] == USE_VAR || slot_use[r] == USE_ANON) begin
							age = now - slot_stamp[r];
							if (!found || age > best) begin
								best = age;
								victim = r;
								found = 1'b1;
							end
						end
					o.evicted = 1'b1;
					o.writeback_needed = vacate(victim, wa, ws);
					if (o.writeback_needed) begin
						o.writeback_addr = wa;
						o.writeback_size = ws;
						o.writeback_reg  = 4'(victim);
					end
				end
				slot_use[victim]   = rq.has_addr ? USE_VAR : USE_ANON;
				slot_addr[victim]  = rq.has_addr ? rq.var_addr : '0;
				slot_size[victim]  = rq.size_bytes;
				slot_flags[victim] = rq.access_flags;
				slot_stamp[victim] = now;
				o.reg_out = 4'(victim);
				o.load_needed = rq.access_flags[FL_READ] && !rq.access_flags[FL_ADDROF];
				o.address_needed = rq.access_flags[FL_ADDROF];
			end
			outcome_q.push_back(o);
		end
		KIND_RELEASE: begin
			o.reg_out = rq.reg_index;
			o.writeback_needed = vacate(int'(rq.reg_index), wa, ws);
			if (o.writeback_needed) begin
				o.writeback_addr = wa;
				o.writeback_size = ws;
				o.writeback_reg  = rq.reg_index;
			end
			outcome_q.push_back(o);
		end
		KIND_RELEASE_MASK: begin
			// one result per set bit, last flag only on the final one
			n = 0;
			for (int r = 0; r < NUM_REGS; r++)
				if (rq.reg_mask[r]) begin
					o = '0;
					o.reg_out = 4'(r);
					o.writeback_needed = vacate(r, wa, ws);
					if (o.writeback_needed) begin
						o.writeback_addr = wa;
						o.writeback_size = ws;
						o.writeback_reg  = 4'(r);
					end
					outcome_q.push_back(o);
					n++;
				end
			if (n > 0) outcome_q[outcome_q.size() - 1].last = 1'b1;
		end
		default: begin
			if (slot_use[rq.reg_index] == USE_FREE) slot_use[rq.reg_index] = USE_FROZEN;
			o.reg_out = rq.reg_index;
			outcome_q.push_back(o);
		end
		endcase
	endfunction

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] seen);
		if (want !== seen) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, seen);
			mismatch_cnt++;
		end
	endfunction

	// Request with every field random
	function automatic req_t any_request(kind_t k);
		req_t rq;
		rq.kind         = k;
		rq.has_addr     = 1'($urandom_range(1));
		rq.var_addr     = $urandom();
		rq.size_bytes   = 4'($urandom_range(15));
		rq.access_flags = 3'($urandom_range(7));
		rq.reg_index    = 4'($urandom_range(15));
		rq.reg_mask     = 16'($urandom_range(16'hffff));
		return rq;
	endfunction

	function automatic req_t acquire_req(logic named, logic [31:0] addr, logic [3:0] sz,
			logic [2:0] fl);
		req_t rq;
		rq = any_request(KIND_ACQUIRE);
		rq.has_addr     = named;
		rq.var_addr     = addr;
		rq.size_bytes   = sz;
		rq.access_flags = fl;
		return rq;
	endfunction

	function automatic req_t index_req(kind_t k, logic [3:0] idx);
		req_t rq;
		rq = any_request(k);
		rq.reg_index = idx;
		return rq;
	endfunction

	function automatic req_t mask_req(logic [15:0] m);
		req_t rq;
		rq = any_request(KIND_RELEASE_MASK);
		rq.reg_mask = m;
		return rq;
	endfunction

	// Mostly well-formed traffic over a small address pool so hits and evictions occur
	function automatic req_t random_request();
		req_t rq;
		int   pick;
		pick = $urandom_range(99);
		if (pick < 68) begin
			rq = any_request(KIND_ACQUIRE);
			rq.has_addr = ($urandom_range(9) != 0);
			if ($urandom_range(4) != 0) rq.var_addr = addr_pool[$urandom_range(ADDR_POOL - 1)];
			if ($urandom_range(7) != 0) begin
				rq.size_bytes = 4'(1 << $urandom_range(3));
				if (rq.access_flags[FL_ADDROF] && $urandom_range(4) != 0) rq.size_bytes = 4'd8;
			end
		end else if (pick < 80) begin
			rq = any_request(KIND_RELEASE);
		end else if (pick < 86) begin
			rq = any_request(KIND_RELEASE_MASK);
			if ($urandom_range(6) == 0) rq.reg_mask = 16'hffff;
			else rq.reg_mask = rq.reg_mask & 16'($urandom_range(16'hffff)) &
					16'($urandom_range(16'hffff));
		end else begin
			rq = any_request(KIND_FREEZE);
		end
		return rq;
	endfunction

	task automatic push_req(req_t rq);
		req_backlog.push_back(rq);
		queued_cnt++;
	endtask

	// Hold until every queued request is accepted and every result has arrived
	task automatic wait_drained();
		while (accepted_cnt != queued_cnt || outcome_q.size() != 0) @(posedge clk);
	endtask

	// Fill a phase with random traffic, sometimes a release-all sweep and refill
	task automatic run_random(int count);
		int n;
		n = 0;
		while (n < count) begin
			if ($urandom_range(24) == 0) begin
				push_req(mask_req(16'hffff));
				for (int i = 0; i < 18; i++)
					push_req(acquire_req(1'b1, addr_pool[$urandom_range(ADDR_POOL - 1)],
							4'(1 << $urandom_range(3)), 3'($urandom_range(3))));
				n += 19;
			end else begin
				push_req(random_request());
				n++;
			end
		end
	endtask

	// Driver: advance to the next request once the current one is taken
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata  <= '0;
			s_axis_tuser  <= '0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				predict_outcomes(cur_req);
				accepted_cnt++;
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (req_backlog.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					cur_req = req_backlog.pop_front();
					s_axis_tdata <= {4'b0, cur_req.reg_mask, cur_req.reg_index,
						cur_req.access_flags, cur_req.size_bytes, cur_req.var_addr,
						cur_req.has_addr};
					s_axis_tuser  <= cur_req.kind;
					s_axis_tvalid <= 1'b1;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// Monitor: check each result against the oldest expectation, stall at random
	always @(posedge clk or negedge arst_n) begin
		res_t want, seen;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				seen.reg_out          = m_axis_tdata[3:0];
				seen.hit              = m_axis_tdata[4];
				seen.load_needed      = m_axis_tdata[5];
				seen.address_needed   = m_axis_tdata[6];
				seen.evicted          = m_axis_tdata[7];
				seen.writeback_needed = m_axis_tdata[8];
				seen.writeback_addr   = m_axis_tdata[40:9];
				seen.writeback_size   = m_axis_tdata[44:41];
				seen.writeback_reg    = m_axis_tdata[48:45];
				seen.status           = status_t'(m_axis_tdata[50:49]);
				seen.last             = m_axis_tlast;
				if (outcome_q.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual %0h last %0b",
						$time, m_axis_tdata, m_axis_tlast);
					mismatch_cnt++;
				end else begin
					want = outcome_q.pop_front();
					check_field("reg_out", want.reg_out, seen.reg_out);
					check_field("hit", want.hit, seen.hit);
					check_field("load_needed", want.load_needed, seen.load_needed);
					check_field("address_needed", want.address_needed, seen.address_needed);
					check_field("evicted", want.evicted, seen.evicted);
					check_field("writeback_needed", want.writeback_needed,
						seen.writeback_needed);
					check_field("writeback_addr", want.writeback_addr, seen.writeback_addr);
					check_field("writeback_size", want.writeback_size, seen.writeback_size);
					check_field("writeback_reg", want.writeback_reg, seen.writeback_reg);
					check_field("status", want.status, seen.status);
					check_field("last", want.last, seen.last);
				end
			end
			if (hold_token != hold_seen) begin
				hold_seen = hold_token;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// Watchdog
	initial begin
		while (cycle_cnt < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("Test completed with failures");
		$finish;
	end

	initial begin
		for (int r = 0; r < NUM_REGS; r++) begin
			slot_use[r]   = USE_FREE;
			slot_addr[r]  = '0;
			slot_size[r]  = '0;
			slot_flags[r] = '0;
			slot_stamp[r] = '0;
		end
		use_tick = '0;
		addr_pool[0] = 32'h0;
		addr_pool[1] = 32'hffff_ffff;
		for (int i = 2; i < ADDR_POOL; i++) addr_pool[i] = $urandom();
		send_idle_pct = 10;
		recv_idle_pct = 62;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// directed: field extremes, each kind, the corner cases
		push_req(index_req(KIND_FREEZE, 4'd15));
		push_req(acquire_req(1'b1, 32'h0, 4'd1, 3'b001));
		push_req(acquire_req(1'b1, 32'h0, 4'd0, 3'b010));
		push_req(acquire_req(1'b1, 32'hffff_ffff, 4'd8, 3'b111));
		push_req(acquire_req(1'b1, 32'h0000_1234, 4'd3, 3'b001));
		push_req(acquire_req(1'b1, 32'h8000_0000, 4'd15, 3'b000));
		push_req(acquire_req(1'b1, 32'h7fff_ffff, 4'd0, 3'b011));
		push_req(acquire_req(1'b1, 32'h0000_0055, 4'd4, 3'b100));
		push_req(acquire_req(1'b0, 32'h0000_0040, 4'd2, 3'b010));
		push_req(acquire_req(1'b0, 32'h0, 4'd8, 3'b111));
		push_req(index_req(KIND_FREEZE, 4'd4));
		push_req(index_req(KIND_FREEZE, 4'd0));
		push_req(index_req(KIND_RELEASE, 4'd0));
		push_req(index_req(KIND_RELEASE, 4'd2));
		push_req(index_req(KIND_RELEASE, 4'd5));
		push_req(mask_req(16'h0000));
		push_req(acquire_req(1'b1, 32'h8000_0000, 4'd2, 3'b010));
		push_req(mask_req(16'hffff));
		push_req(index_req(KIND_RELEASE, 4'd15));
		wait_drained();

		// phase one: light sender idling, heavy receiver stalls, one long hold-off
		run_random(15);
		wait_drained();
		hold_token++;
		run_random(62);
		wait_drained();

		// phase two: roles swapped, plus every entry frozen before an acquire
		send_idle_pct = 62;
		recv_idle_pct = 10;
		push_req(mask_req(16'hffff));
		for (int i = 0; i < NUM_REGS; i++) push_req(index_req(KIND_FREEZE, 4'(i)));
		push_req(acquire_req(1'b1, addr_pool[3], 4'd4, 3'b011));
		push_req(acquire_req(1'b0, 32'h0, 4'd1, 3'b001));
		push_req(mask_req(16'hffff));
		run_random(58);
		wait_drained();

		// phase three: no idling
		send_idle_pct = 0;
		recv_idle_pct = 0;
		run_random(56);
		wait_drained();

		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_cnt == 0 && outcome_q.size() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

// File: files.f
+incdir+hdl
hdl/lra_pkg.sv
hdl/lra_ctrl.sv
hdl/lra_dp.sv
hdl/lru_register_allocator.sv
tb/tb_top.sv
